FILE: rtl/cagnms_pkg.sv
// Package for the class-aware greedy NMS core: sizes, entry layout, sequencer states.
// Used by every RTL file of the block but the generic memory; depends on nothing.
`default_nettype none

package cagnms_pkg;

    // Store depth and the cap on kept items per set.
    localparam int MAX_BOXES = 64;
    localparam int OUT_LIMIT = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int NK_W      = $clog2(OUT_LIMIT + 1);

    // Field widths.
    localparam int CLS_W   = 5;
    localparam int SCORE_W = 16;
    localparam int COORD_W = 12;
    localparam int THR_W   = 16;

    // Overlap arithmetic widths.
    localparam int EXT_W   = 13;  // overlap extent, at most 4096
    localparam int AREA_W  = 24;  // w*h of one box
    localparam int OVER_W  = 25;  // intersection area, at most 2^24
    localparam int UNI_W   = 27;  // signed union area
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = '0;
    localparam logic [THR_W-1:0]     THR_RESET     = 16'd19661;

    // One stored detection.
    typedef struct packed {
        logic [CLS_W-1:0]          cls;
        logic [SCORE_W-1:0]        score;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COORD_W-1:0]        w;
        logic [COORD_W-1:0]        h;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
    localparam int KEPT_W  = ENTRY_W + 1;

    // Main sequencer.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_END,
        S_A_RD,
        S_A_LD,
        S_B_RD,
        S_B_CHK,
        S_IOU,
        S_FLUSH
    } t_state;

    // Steps of the shared overlap unit.
    typedef enum logic [2:0] {
        IOU_IDLE,
        IOU_EXT,
        IOU_OVER,
        IOU_AREA_A,
        IOU_AREA_B,
        IOU_UNION,
        IOU_THR,
        IOU_CMP
    } t_iou_step;

    // Result of one overlap test.
    typedef struct packed {
        logic done;
        logic hit;
    } t_iou_res;

endpackage

`default_nettype wire

FILE: rtl/cagnms_intf.sv
// Valid/ready channel interfaces for detections in and kept detections out.
// Depends on cagnms_pkg for the field widths.
`default_nettype none

interface cagnms_det_if;
    import cagnms_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CLS_W-1:0]          class_id;
    logic [SCORE_W-1:0]        score;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic [COORD_W-1:0]        box_w;
    logic [COORD_W-1:0]        box_h;
    logic                      last_in;

    modport source (output valid, class_id, score, box_x, box_y, box_w, box_h, last_in,
                    input ready);
    modport sink   (input valid, class_id, score, box_x, box_y, box_w, box_h, last_in,
                    output ready);
endinterface

interface cagnms_kept_if;
    import cagnms_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CLS_W-1:0]          kept_class;
    logic [SCORE_W-1:0]        kept_score;
    logic signed [COORD_W-1:0] kept_x;
    logic signed [COORD_W-1:0] kept_y;
    logic [COORD_W-1:0]        kept_w;
    logic [COORD_W-1:0]        kept_h;
    logic                      last_out;

    modport source (output valid, kept_class, kept_score, kept_x, kept_y, kept_w, kept_h,
                    last_out, input ready);
    modport sink   (input valid, kept_class, kept_score, kept_x, kept_y, kept_w, kept_h,
                    last_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/cagnms_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Holds the sorted detection store; no dependencies.
`default_nettype none

module cagnms_ram #(
    parameter int DATA_W = 69,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cagnms_cfg.sv
// APB-style register file holding the overlap threshold.
// Depends on cagnms_pkg for the register map and reset value.
`default_nettype none

module cagnms_cfg import cagnms_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [THR_W-1:0]      o_threshold
);

    logic [THR_W-1:0]     r_thr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_hit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_hit  = psel && penable && pwrite && pready && (reg_idx == REG_THRESHOLD);

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (wr_hit) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // Read decode.
    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = {{(APB_DATA_W-THR_W){1'b0}}, r_thr};
            default:       prdata = '0;
        endcase
    end

    assign o_threshold = r_thr;

endmodule

`default_nettype wire

FILE: rtl/cagnms_iou.sv
// Multi-cycle overlap test built around one shared multiplier.
// Depends on cagnms_pkg for the entry layout, widths and step codes.
`default_nettype none

module cagnms_iou import cagnms_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  t_entry                i_a,
    input  t_entry                i_b,
    input  wire logic [THR_W-1:0] i_thr,
    output t_iou_res              o_res
);

    t_iou_step                r_step, n_step;
    t_entry                   r_b;
    logic [EXT_W-1:0]         r_ow, r_oh;
    logic [OVER_W-1:0]        r_over;
    logic [AREA_W-1:0]        r_aa, r_ab;
    logic signed [UNI_W-1:0]  r_uni;
    logic [PROD_W-1:0]        r_prod;
    logic [MUL_A_W-1:0]       op_a;
    logic [MUL_B_W-1:0]       op_b;
    logic [PROD_W-1:0]        prod;
    logic                     uni_le_zero;

    // Inclusive overlap extent along one axis, clamped at zero.
    function automatic logic [EXT_W-1:0] f_extent(
        input logic signed [COORD_W-1:0] p0,
        input logic [COORD_W-1:0]        l0,
        input logic signed [COORD_W-1:0] p1,
        input logic [COORD_W-1:0]        l1
    );
        logic signed [COORD_W+1:0] e0, e1, lo, hi, s0, s1;
        logic signed [COORD_W+2:0] d;
        s0 = $signed({{2{p0[COORD_W-1]}}, p0});
        s1 = $signed({{2{p1[COORD_W-1]}}, p1});
        e0 = s0 + $signed({2'b00, l0});
        e1 = s1 + $signed({2'b00, l1});
        lo = (e0 < e1) ? e0 : e1;
        hi = (s0 > s1) ? s0 : s1;
        d  = $signed({lo[COORD_W+1], lo}) - $signed({hi[COORD_W+1], hi})
             + $signed((COORD_W+3)'(1));
        return (d > 0) ? d[EXT_W-1:0] : '0;
    endfunction

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_step)
            IOU_OVER: begin
                op_a = MUL_A_W'(r_ow);
                op_b = MUL_B_W'(r_oh);
            end
            IOU_AREA_A: begin
                op_a = MUL_A_W'(i_a.w);
                op_b = MUL_B_W'(i_a.h);
            end
            IOU_AREA_B: begin
                op_a = MUL_A_W'(r_b.w);
                op_b = MUL_B_W'(r_b.h);
            end
            IOU_THR: begin
                op_a = i_thr;
                op_b = r_uni[MUL_B_W-1:0];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod        = PROD_W'(op_a) * PROD_W'(op_b);
    assign uni_le_zero = r_uni[UNI_W-1] || (r_uni == '0);

    // Step sequencing.
    always_comb begin
        n_step = r_step;
        unique case (r_step)
            IOU_IDLE:   if (i_start) n_step = IOU_EXT;
            IOU_EXT:    n_step = IOU_OVER;
            IOU_OVER:   n_step = IOU_AREA_A;
            IOU_AREA_A: n_step = IOU_AREA_B;
            IOU_AREA_B: n_step = IOU_UNION;
            IOU_UNION:  n_step = IOU_THR;
            IOU_THR:    n_step = uni_le_zero ? IOU_IDLE : IOU_CMP;
            IOU_CMP:    n_step = IOU_IDLE;
            default:    n_step = IOU_IDLE;
        endcase
    end

    // Result: a degenerate union suppresses on any overlap, else cross-multiplied compare.
    always_comb begin
        o_res = '0;
        unique case (r_step)
            IOU_THR: begin
                o_res.done = uni_le_zero;
                o_res.hit  = uni_le_zero && (r_over != '0);
            end
            IOU_CMP: begin
                o_res.done = 1'b1;
                o_res.hit  = {1'b0, r_over, 16'b0} > r_prod;
            end
            default: o_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= IOU_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Datapath registers, at most one product per step.
    always_ff @(posedge i_clk) begin
        if (r_step == IOU_IDLE && i_start) begin
            r_b <= i_b;
        end
        if (r_step == IOU_EXT) begin
            r_ow <= f_extent(i_a.x, i_a.w, r_b.x, r_b.w);
            r_oh <= f_extent(i_a.y, i_a.h, r_b.y, r_b.h);
        end
        if (r_step == IOU_OVER) begin
            r_over <= prod[OVER_W-1:0];
        end
        if (r_step == IOU_AREA_A) begin
            r_aa <= prod[AREA_W-1:0];
        end
        if (r_step == IOU_AREA_B) begin
            r_ab <= prod[AREA_W-1:0];
        end
        if (r_step == IOU_UNION) begin
            r_uni <= $signed(UNI_W'(r_aa)) + $signed(UNI_W'(r_ab)) - $signed(UNI_W'(r_over));
        end
        if (r_step == IOU_THR) begin
            r_prod <= prod;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/class_aware_greedy_nms_core.sv
// Class-aware greedy NMS core: sorted detection store, sequencer and output stage.
// Depends on cagnms_pkg, cagnms_intf, cagnms_ram, cagnms_iou and cagnms_cfg.
//
//   channel   dir  handshake        payload
//   i_det     in   valid / ready    class_id score box_x box_y box_w box_h last_in
//   o_kept    out  valid / ready    kept_class kept_score kept_x..kept_h last_out
//   apb       in   psel / penable   paddr pwdata -> prdata, pready tied high
//
// Insertion of one detection moves each lower-scored store entry down a slot by a read
// and a write, as the store memory has a single read port. On last_in the suppression
// pass reads each unsuppressed entry as an anchor, skips entries already suppressed,
// passes over entries of another class and runs an overlap test on the rest, the tests
// sharing one multiplier. i_det.ready is high only while idle.
// A stalled o_kept holds the sequencer at the next kept item; reset is synchronous.
`default_nettype none

module class_aware_greedy_nms_core import cagnms_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    cagnms_det_if.sink                 i_det,
    cagnms_kept_if.source              o_kept,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_state               r_state, n_state;
    t_entry               r_new, n_new;
    t_entry               r_anc, n_anc;
    t_entry               r_out, n_out;
    logic                 r_last, n_last;
    logic                 r_full_chk, n_full_chk;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_j, n_j;
    logic [NK_W-1:0]      r_nk, n_nk;
    logic [MAX_BOXES-1:0] r_flags, n_flags;
    logic                 r_anc_v, n_anc_v;
    logic                 r_out_v, n_out_v;
    logic                 r_out_last, n_out_last;

    logic                 ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
    t_entry               ram_wr_data, ram_q;
    logic                 iou_start;
    t_iou_res             iou_res;
    logic [THR_W-1:0]     thr;
    logic                 out_free;
    logic                 new_ge;
    logic                 store_full;
    t_entry               in_entry;

    // Submodules.
    cagnms_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (MAX_BOXES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    cagnms_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (iou_start),
        .i_a     (r_anc),
        .i_b     (ram_q),
        .i_thr   (thr),
        .o_res   (iou_res)
    );

    cagnms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (thr)
    );

    // Shared conditions.
    assign out_free   = !r_out_v || o_kept.ready;
    assign new_ge     = ram_q.score >= r_new.score;
    assign store_full = (r_cnt == CNT_W'(MAX_BOXES));

    always_comb begin
        in_entry.cls   = i_det.class_id;
        in_entry.score = i_det.score;
        in_entry.x     = i_det.box_x;
        in_entry.y     = i_det.box_y;
        in_entry.w     = i_det.box_w;
        in_entry.h     = i_det.box_h;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_det.valid) n_state = S_INS_RD;
            end
            S_INS_RD: begin
                if (!r_full_chk && r_idx == '0) n_state = S_INS_END;
                else                            n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (new_ge) n_state = S_INS_END;
                else        n_state = S_INS_RD;
            end
            S_INS_END: begin
                n_state = r_last ? S_A_RD : S_IDLE;
            end
            S_A_RD: begin
                if (r_i == r_cnt)                      n_state = S_FLUSH;
                else if (!r_flags[r_i[IDX_W-1:0]])     n_state = S_A_LD;
            end
            S_A_LD: begin
                if (!r_anc_v || out_free) begin
                    if (r_nk + 1'b1 == NK_W'(OUT_LIMIT)) n_state = S_FLUSH;
                    else                                 n_state = S_B_RD;
                end
            end
            S_B_RD: begin
                if (r_j == r_cnt)                      n_state = S_A_RD;
                else if (!r_flags[r_j[IDX_W-1:0]])     n_state = S_B_CHK;
            end
            S_B_CHK: begin
                n_state = (ram_q.cls != r_anc.cls) ? S_B_RD : S_IOU;
            end
            S_IOU: begin
                if (iou_res.done) n_state = S_B_RD;
            end
            S_FLUSH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath next values.
    always_comb begin
        n_new       = r_new;
        n_last      = r_last;
        n_full_chk  = r_full_chk;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_nk        = r_nk;
        n_flags     = r_flags;
        n_anc       = r_anc;
        n_anc_v     = r_anc_v;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_v     = o_kept.ready ? 1'b0 : r_out_v;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = r_new;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx;
        iou_start   = 1'b0;
        i_det.ready = 1'b0;

        unique case (r_state)
            // Take an item; a full store first checks whether it beats the bottom entry.
            S_IDLE: begin
                i_det.ready = 1'b1;
                if (i_det.valid) begin
                    n_new  = in_entry;
                    n_last = i_det.last_in;
                    if (store_full) begin
                        n_full_chk = 1'b1;
                    end else begin
                        n_full_chk = 1'b0;
                        n_idx      = r_cnt[IDX_W-1:0];
                        n_cnt      = r_cnt + 1'b1;
                    end
                end
            end
            // Read the entry above the hole, or drop the new item into slot zero.
            S_INS_RD: begin
                if (!r_full_chk && r_idx == '0) begin
                    ram_wr_en = 1'b1;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_full_chk ? IDX_W'(MAX_BOXES - 1) : r_idx - 1'b1;
                end
            end
            // Equal scores stay ahead of the newcomer; lower ones move down a slot.
            S_INS_CMP: begin
                if (r_full_chk) begin
                    if (!new_ge) begin
                        n_full_chk = 1'b0;
                        n_idx      = IDX_W'(MAX_BOXES - 1);
                    end
                end else if (new_ge) begin
                    ram_wr_en = 1'b1;
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_q;
                    n_idx       = r_idx - 1'b1;
                end
            end
            // Start suppression on the final item of a set.
            S_INS_END: begin
                if (r_last) begin
                    n_flags = '0;
                    n_i     = '0;
                    n_nk    = '0;
                end
            end
            // Next anchor candidate.
            S_A_RD: begin
                if (r_i != r_cnt) begin
                    if (r_flags[r_i[IDX_W-1:0]]) begin
                        n_i = r_i + 1'b1;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_i[IDX_W-1:0];
                    end
                end
            end
            // New anchor is kept; the previous one is known not to be last.
            S_A_LD: begin
                if (!r_anc_v || out_free) begin
                    if (r_anc_v) begin
                        n_out_v    = 1'b1;
                        n_out      = r_anc;
                        n_out_last = 1'b0;
                    end
                    n_anc   = ram_q;
                    n_anc_v = 1'b1;
                    n_nk    = r_nk + 1'b1;
                    n_j     = r_i + 1'b1;
                end
            end
            // Next later entry to test against the anchor.
            S_B_RD: begin
                if (r_j == r_cnt) begin
                    n_i = r_i + 1'b1;
                end else if (r_flags[r_j[IDX_W-1:0]]) begin
                    n_j = r_j + 1'b1;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_j[IDX_W-1:0];
                end
            end
            // Only entries of the anchor's class go through the overlap test.
            S_B_CHK: begin
                if (ram_q.cls != r_anc.cls) begin
                    n_j = r_j + 1'b1;
                end else begin
                    iou_start = 1'b1;
                end
            end
            S_IOU: begin
                if (iou_res.done) begin
                    if (iou_res.hit) n_flags[r_j[IDX_W-1:0]] = 1'b1;
                    n_j = r_j + 1'b1;
                end
            end
            // Last kept item of the set; the store empties.
            S_FLUSH: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = r_anc;
                    n_out_last = 1'b1;
                    n_anc_v    = 1'b0;
                    n_cnt      = '0;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_full_chk <= 1'b0;
            r_last     <= 1'b0;
            r_cnt      <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_nk       <= '0;
            r_flags    <= '0;
            r_anc_v    <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_full_chk <= n_full_chk;
            r_last     <= n_last;
            r_cnt      <= n_cnt;
            r_i        <= n_i;
            r_j        <= n_j;
            r_nk       <= n_nk;
            r_flags    <= n_flags;
            r_anc_v    <= n_anc_v;
            r_out_v    <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_new      <= n_new;
        r_idx      <= n_idx;
        r_anc      <= n_anc;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // Output channel.
    assign o_kept.valid      = r_out_v;
    assign o_kept.kept_class = r_out.cls;
    assign o_kept.kept_score = r_out.score;
    assign o_kept.kept_x     = r_out.x;
    assign o_kept.kept_y     = r_out.y;
    assign o_kept.kept_w     = r_out.w;
    assign o_kept.kept_h     = r_out.h;
    assign o_kept.last_out   = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/cagnms_checker.sv
// Port-level checker for the class-aware greedy NMS core, with its bind statement.
// Depends on cagnms_pkg and on the top level's port names.
`default_nettype none

module cagnms_checker import cagnms_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_det_valid,
    input wire logic                  i_det_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [KEPT_W-1:0]     i_out_data,
    input wire logic                  i_psel,
    input wire logic                  i_penable,
    input wire logic                  i_pwrite,
    input wire logic [PADDR_W-1:0]    i_paddr,
    input wire logic [APB_DATA_W-1:0] i_pwdata,
    input wire logic [APB_DATA_W-1:0] i_prdata
);

    // A kept item waiting on the sink neither vanishes nor changes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("kept item changed while stalled");

    // The block works on one detection at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_det_valid && i_det_ready |=> !i_det_ready)
        else $error("detection accepted while still busy");

    // Reset leaves the block idle with nothing to send.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_det_ready)
        else $error("block not idle after reset");

    // A threshold write reads back on the next cycle.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && (i_paddr[PADDR_W-1:2] == REG_THRESHOLD)
        |=> (i_paddr[PADDR_W-1:2] != REG_THRESHOLD) ||
            (i_prdata[THR_W-1:0] == $past(i_pwdata[THR_W-1:0])))
        else $error("threshold readback mismatch");

endmodule

bind class_aware_greedy_nms_core cagnms_checker u_cagnms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_det_valid (i_det.valid),
    .i_det_ready (i_det.ready),
    .i_out_valid (o_kept.valid),
    .i_out_ready (o_kept.ready),
    .i_out_data  ({o_kept.kept_class, o_kept.kept_score, o_kept.kept_x, o_kept.kept_y,
                   o_kept.kept_w, o_kept.kept_h, o_kept.last_out}),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking bench for class_aware_greedy_nms_core: detections are sent in sets, each kept
// item is compared with a built-in NMS predictor or a typed want; APB sets the threshold.
// Depends on cagnms_pkg, the channel interfaces in cagnms_intf and the core RTL.
`timescale 1ns / 100ps

module testbench;
    import cagnms_pkg::*;

    localparam int IDLE_LIMIT   = 200000;
    localparam int SETTLE_CYC   = 2 * MAX_BOXES + 16;
    localparam int LONG_HOLD    = 800;
    localparam int HOLD_EVERY   = 150;
    localparam int RANDOM_ITEMS = 392;
    localparam int PHASES       = 6;
    localparam int N_OPEN       = 18;
    localparam logic [PADDR_W-1:0] THR_ADDR = {REG_THRESHOLD, 2'b00};

    // One expected or observed kept item.
    typedef struct packed {
        t_entry det;
        logic   last;
    } t_kept_item;

    // One row of the opening stimulus; want is only meaningful when typed is set.
    typedef struct packed {
        t_entry det;
        logic   last;
        logic   typed;
        t_entry want;
    } t_stim_row;

    localparam t_entry NO_ENTRY = '0;
    localparam t_entry EXT_HI   = '{5'd31, 16'hFFFF, 12'h800, 12'h7FF, 12'hFFF, 12'hFFF};
    localparam t_entry EXT_LO   = '{5'd0, 16'h0000, 12'h7FF, 12'h800, 12'h000, 12'h000};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cagnms_det_if  det_ch ();
    cagnms_kept_if kept_ch ();

    class_aware_greedy_nms_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_det   (det_ch),
        .o_kept  (kept_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: the sorted detection store and the active threshold.
    t_entry           sorted_dets[$];
    logic [THR_W-1:0] iou_thr;
    t_kept_item       kept_due[$];
    int               fail_count  = 0;
    int               kept_seen   = 0;
    int               quiet_cycles = 0;

    // Opening stimulus: extremes, suppression, ties, zero union, touching edges, high classes.
    t_stim_row opening_rows [N_OPEN] = '{
        '{EXT_HI, 1'b1, 1'b1, EXT_HI},
        '{EXT_LO, 1'b1, 1'b1, EXT_LO},
        '{'{5'd2, 16'd40000, 12'd100, 12'd100, 12'd50, 12'd40}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd2, 16'd30000, 12'd100, 12'd100, 12'd50, 12'd40}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd20, 16'd35000, 12'd100, 12'd100, 12'd50, 12'd40}, 1'b1, 1'b0, NO_ENTRY},
        '{'{5'd5, 16'd1000, 12'hE0C, 12'hE0C, 12'd30, 12'd30}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd6, 16'd1000, 12'hE0C, 12'hE0C, 12'd30, 12'd30}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd5, 16'd1000, 12'hE0C, 12'hE0C, 12'd30, 12'd30}, 1'b1, 1'b0, NO_ENTRY},
        '{'{5'd7, 16'd500, 12'd10, 12'd10, 12'd0, 12'd0}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd7, 16'd400, 12'd10, 12'd10, 12'd0, 12'd0}, 1'b1, 1'b0, NO_ENTRY},
        '{'{5'd8, 16'd500, 12'd10, 12'd10, 12'd0, 12'd0}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd8, 16'd400, 12'd12, 12'd10, 12'd0, 12'd0}, 1'b1, 1'b0, NO_ENTRY},
        '{'{5'd1, 16'd900, 12'd0, 12'd0, 12'd10, 12'd10}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd1, 16'd800, 12'd10, 12'd0, 12'd10, 12'd10}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd1, 16'd700, 12'd2, 12'd1, 12'd10, 12'd10}, 1'b1, 1'b0, NO_ENTRY},
        '{'{5'd25, 16'hFFFF, 12'h7FF, 12'h7FF, 12'hFFF, 12'hFFF}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd25, 16'hFFFE, 12'h7FF, 12'h7FF, 12'hFFF, 12'hFFF}, 1'b0, 1'b0, NO_ENTRY},
        '{'{5'd31, 16'hFFFF, 12'h7FF, 12'h7FF, 12'hFFF, 12'hFFF}, 1'b1, 1'b0, NO_ENTRY}
    };

    // Free-running clock, 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Overlap test with inclusive extents, cross-multiplied against the threshold.
    function automatic bit overlap_kills(t_entry a, t_entry b, logic [THR_W-1:0] thr);
        longint ax, ay, bx, by, aw, ah, bw, bh;
        longint ow, oh, over, uni;
        ax = longint'($signed(a.x));
        ay = longint'($signed(a.y));
        bx = longint'($signed(b.x));
        by = longint'($signed(b.y));
        aw = longint'(a.w);
        ah = longint'(a.h);
        bw = longint'(b.w);
        bh = longint'(b.h);
        ow = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - ((ax > bx) ? ax : bx) + 1;
        oh = ((ay + ah < by + bh) ? ay + ah : by + bh) - ((ay > by) ? ay : by) + 1;
        if (ow < 0) ow = 0;
        if (oh < 0) oh = 0;
        over = ow * oh;
        uni  = aw * ah + bw * bh - over;
        if (uni <= 0) return over > 0;
        return over * 65536 > longint'(thr) * uni;
    endfunction

    // Inserts one detection in score order; on the last one of a set runs greedy NMS.
    function automatic void take_detection(input t_entry d, input logic last_in,
                                           output t_kept_item found[$]);
        int pos;
        bit gone [MAX_BOXES];
        found.delete();
        pos = 0;
        while (pos < sorted_dets.size() && sorted_dets[pos].score >= d.score) pos++;
        if (pos < MAX_BOXES) begin
            sorted_dets.insert(pos, d);
            if (sorted_dets.size() > MAX_BOXES) void'(sorted_dets.pop_back());
        end
        if (!last_in) return;
        foreach (gone[k]) gone[k] = 1'b0;
        for (int i = 0; i < sorted_dets.size(); i++) begin
            if (gone[i]) continue;
            if (found.size() < OUT_LIMIT) found.push_back('{sorted_dets[i], 1'b0});
            for (int j = i + 1; j < sorted_dets.size(); j++) begin
                if (!gone[j] && sorted_dets[j].cls == sorted_dets[i].cls &&
                    overlap_kills(sorted_dets[i], sorted_dets[j], iou_thr))
                    gone[j] = 1'b1;
            end
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        sorted_dets.delete();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Offers one item and waits for the edge that accepts it; called at a rising edge.
    task automatic send_det(input t_entry d, input logic last_in, input int gap,
                            input logic typed, input t_entry want);
        t_kept_item found[$];
        if (gap > 0) begin
            det_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        det_ch.valid    <= 1'b1;
        det_ch.class_id <= d.cls;
        det_ch.score    <= d.score;
        det_ch.box_x    <= d.x;
        det_ch.box_y    <= d.y;
        det_ch.box_w    <= d.w;
        det_ch.box_h    <= d.h;
        det_ch.last_in  <= last_in;
        do @(posedge i_clk); while (det_ch.ready !== 1'b1);
        take_detection(d, last_in, found);
        if (typed) begin
            kept_due.push_back('{want, 1'b1});
        end else begin
            foreach (found[k]) kept_due.push_back(found[k]);
        end
    endtask

    // Stops offering and waits until every expected item is out and the core has settled.
    task automatic wait_drained();
        det_ch.valid <= 1'b0;
        while (kept_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic apb_write_thr(input logic [THR_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THR_ADDR;
        pwdata  <= APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        iou_thr = v;
    endtask

    task automatic apb_read_thr();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THR_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        check_field("overlap_threshold", longint'(iou_thr), longint'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random set. Unless spread is set, most items sit in a few clusters of a few classes
    // so that suppression happens; the rest, or all if spread, span the full field ranges.
    task automatic run_random_set(input int n, input bit spread);
        t_entry d;
        int     cx [4];
        int     cy [4];
        int     n_clusters;
        int     c;
        int     r;
        bit     burst;
        burst      = ($urandom_range(0, 3) == 0);
        n_clusters = $urandom_range(1, 4);
        foreach (cx[k]) begin
            cx[k] = int'($urandom_range(0, 3800)) - 1900;
            cy[k] = int'($urandom_range(0, 3800)) - 1900;
        end
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (spread || r >= 90) d.cls = CLS_W'($urandom_range(0, 31));
            else if (r < 75)       d.cls = CLS_W'($urandom_range(0, 3));
            else                   d.cls = CLS_W'($urandom_range(0, 20));
            r = $urandom_range(0, 99);
            if (r < 65)      d.score = SCORE_W'($urandom);
            else if (r < 85) d.score = SCORE_W'($urandom_range(0, 7) * 8192);
            else if (r < 92) d.score = '1;
            else             d.score = '0;
            c = $urandom_range(0, n_clusters - 1);
            if (!spread && $urandom_range(0, 99) < 80) begin
                d.x = COORD_W'(cx[c] + int'($urandom_range(0, 24)) - 12);
                d.y = COORD_W'(cy[c] + int'($urandom_range(0, 24)) - 12);
                d.w = COORD_W'($urandom_range(0, 120));
                d.h = COORD_W'($urandom_range(0, 120));
            end else begin
                d.x = COORD_W'($urandom);
                d.y = COORD_W'($urandom);
                d.w = COORD_W'($urandom);
                d.h = COORD_W'($urandom);
            end
            if ($urandom_range(0, 19) == 0) d.w = '0;
            if ($urandom_range(0, 19) == 0) d.h = '0;
            send_det(d, i == n - 1, burst ? 0 : pick_gap(), 1'b0, NO_ENTRY);
        end
    endtask

    // Compares one accepted kept item with the oldest expectation.
    task automatic check_kept();
        t_kept_item want;
        if (kept_due.size() == 0) begin
            $error("kept item with nothing expected: class %0d score %0d",
                   kept_ch.kept_class, kept_ch.kept_score);
            fail_count++;
        end else begin
            want = kept_due.pop_front();
            check_field("kept_class", longint'(want.det.cls), longint'(kept_ch.kept_class));
            check_field("kept_score", longint'(want.det.score), longint'(kept_ch.kept_score));
            check_field("kept_x", longint'($signed(want.det.x)),
                        longint'($signed(kept_ch.kept_x)));
            check_field("kept_y", longint'($signed(want.det.y)),
                        longint'($signed(kept_ch.kept_y)));
            check_field("kept_w", longint'(want.det.w), longint'(kept_ch.kept_w));
            check_field("kept_h", longint'(want.det.h), longint'(kept_ch.kept_h));
            check_field("last_out", longint'(want.last), longint'(kept_ch.last_out));
        end
        kept_seen++;
    endtask

    // Result side: short random stalls, runs of steady ready, and now and then a long
    // hold-off so that the core backs up and closes its input.
    initial begin
        int stall_left;
        int hold_left;
        int next_hold;
        int cyc;
        int r;
        stall_left = 0;
        hold_left  = 0;
        next_hold  = 40;
        cyc        = 0;
        kept_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (kept_ch.valid === 1'b1 && kept_ch.ready === 1'b1) check_kept();
            if (kept_seen >= next_hold) begin
                hold_left = LONG_HOLD;
                next_hold = kept_seen + HOLD_EVERY;
            end
            if (hold_left > 0) begin
                hold_left--;
                kept_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                kept_ch.ready <= 1'b0;
            end else if ((cyc / 400) % 3 == 0) begin
                kept_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    stall_left = $urandom_range(0, 3);
                    kept_ch.ready <= 1'b0;
                end else if (r < 12) begin
                    stall_left = $urandom_range(10, 50);
                    kept_ch.ready <= 1'b0;
                end else begin
                    kept_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((det_ch.valid === 1'b1 && det_ch.ready === 1'b1) ||
            (kept_ch.valid === 1'b1 && kept_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence: reset, opening rows, then random phases at several thresholds.
    initial begin
        logic [THR_W-1:0] thr_plan [PHASES];
        int               phase_items;
        int               n;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        det_ch.valid    <= 1'b0;
        det_ch.class_id <= '0;
        det_ch.score    <= '0;
        det_ch.box_x    <= '0;
        det_ch.box_y    <= '0;
        det_ch.box_w    <= '0;
        det_ch.box_h    <= '0;
        det_ch.last_in  <= 1'b0;
        thr_plan = '{16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd32768, THR_RESET};
        thr_plan[2] = THR_W'($urandom_range(0, 65535));
        iou_thr = THR_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_read_thr();

        foreach (opening_rows[k])
            send_det(opening_rows[k].det, opening_rows[k].last, pick_gap(),
                     opening_rows[k].typed, opening_rows[k].want);
        wait_drained();

        // Phase 1 fills the store with spread boxes at the highest threshold, so the
        // full 64 come out; phase 3 overflows a clustered store at the lowest nonzero one.
        for (int phase = 0; phase < PHASES; phase++) begin
            apb_write_thr(thr_plan[phase]);
            apb_read_thr();
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / PHASES) begin
                if (phase_items == 0 && (phase == 1 || phase == 3))
                    n = $urandom_range(66, 76);
                else if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(13, 30);
                else
                    n = $urandom_range(1, 12);
                run_random_set(n, phase == 1);
                phase_items += n;
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/cagnms_pkg.sv
rtl/cagnms_intf.sv
rtl/cagnms_ram.sv
rtl/cagnms_cfg.sv
rtl/cagnms_iou.sv
rtl/class_aware_greedy_nms_core.sv
rtl/cagnms_checker.sv
tb/sv/testbench.sv
